/* rtl/rrac_pkg.sv */
// Package: constants, types and AES byte functions for the reduced-round cipher.
`timescale 1ns / 1ps
package rrac_pkg;

    localparam int unsigned MaxRoundsDefault = 14;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_KEY0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY3 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_KSIZE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ROUNDS = 3'd5;

    localparam logic [1:0] KSIZE_128 = 2'd0;
    localparam logic [1:0] KSIZE_192 = 2'd1;

    localparam logic REQ_ENC = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte n of the block sits at bits [127-8n -: 8]; state (row r, col c) is byte 4c+r.
    function automatic logic [7:0] get_b(input t_block s, input int unsigned n);
        get_b = s[127-8*n -: 8];
    endfunction

    function automatic t_block enc_sr_sb(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = sbox(get_b(s, 4*((c+r)%4)+r));
        enc_sr_sb = o;
    endfunction

    function automatic t_block dec_sr_sb(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = inv_sbox(get_b(s, 4*((c+4-r)%4)+r));
        dec_sr_sb = o;
    endfunction

    function automatic t_block mix_cols(input t_block s, input logic inv);
        t_block o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                a0 = get_b(s, 4*c+r);
                a1 = get_b(s, 4*c+(r+1)%4);
                a2 = get_b(s, 4*c+(r+2)%4);
                a3 = get_b(s, 4*c+(r+3)%4);
                if (inv)
                    o[127-8*(4*c+r) -: 8] = gmul(a0, 4'he) ^ gmul(a1, 4'hb)
                                          ^ gmul(a2, 4'hd) ^ gmul(a3, 4'h9);
                else
                    o[127-8*(4*c+r) -: 8] = gmul(a0, 4'h2) ^ gmul(a1, 4'h3) ^ a2 ^ a3;
            end
        mix_cols = o;
    endfunction

endpackage

/* rtl/rrac_key_expand.sv */
// Key schedule: expands the key one word per cycle into the round key memory.
`timescale 1ns / 1ps
module rrac_key_expand #(
    parameter int unsigned MAX_ROUNDS = rrac_pkg::MaxRoundsDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [255:0]                          i_key,
    input  logic [1:0]                            i_key_size,
    output logic                                  o_busy,
    output logic                                  o_we,
    output logic [$clog2(4*(MAX_ROUNDS+1))-1:0]   o_waddr,
    output logic [31:0]                           o_wdata,
    output logic [3:0]                            o_nr
);
    import rrac_pkg::*;

    localparam int unsigned Depth = 4 * (MAX_ROUNDS + 1);
    localparam int unsigned AW = $clog2(Depth);

    logic          r_busy;
    logic [AW-1:0] r_idx;
    logic [2:0]    r_pos;
    logic [7:0]    r_rc;
    logic [31:0]   r_win [8];
    logic [3:0]    r_nk;
    logic [3:0]    r_nr;
    logic [AW-1:0] r_last;

    logic [31:0] n_word;
    logic [31:0] n_t;
    logic [3:0]  n_nk;
    logic [3:0]  n_nr;

    always_comb begin
        unique case (i_key_size)
            KSIZE_128: begin n_nk = 4'd4; n_nr = 4'd10; end
            KSIZE_192: begin n_nk = 4'd6; n_nr = 4'd12; end
            default:   begin n_nk = 4'd8; n_nr = 4'd14; end
        endcase
        if (n_nr > 4'(MAX_ROUNDS)) n_nr = 4'(MAX_ROUNDS);
    end

    // r_win[0] is word i-nk, r_win[nk-1] is word i-1
    always_comb begin
        n_t = r_win[r_nk[2:0] - 3'd1];
        if (r_pos == 3'd0) begin
            n_t = sub_word({n_t[23:0], n_t[31:24]}) ^ {r_rc, 24'h0};
        end else if (r_nk == 4'd8 && r_pos == 3'd4) begin
            n_t = sub_word(n_t);
        end
        n_word = (32'(r_idx) < 32'(r_nk)) ? r_win[r_idx[2:0]] : (r_win[0] ^ n_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_idx == r_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= '0;
            r_pos  <= 3'd0;
            r_rc   <= 8'h01;
            r_nk   <= n_nk;
            r_nr   <= n_nr;
            r_last <= AW'(4 * n_nr + 3);
            for (int k = 0; k < 8; k++) r_win[k] <= i_key[255-32*k -: 32];
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (32'(r_idx) >= 32'(r_nk)) begin
                for (int k = 0; k < 7; k++)
                    r_win[k] <= (k == 32'(r_nk) - 1) ? n_word : r_win[k+1];
                r_win[7] <= (r_nk == 4'd8) ? n_word : r_win[7];
                r_pos <= (r_pos + 3'd1 == r_nk[2:0]) || (r_nk == 4'd8 && r_pos == 3'd7)
                         ? 3'd0 : r_pos + 3'd1;
                if (r_pos == 3'd0) r_rc <= xt(r_rc);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_we    = r_busy;
    assign o_waddr = r_idx;
    assign o_wdata = n_word;
    assign o_nr    = r_nr;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("expansion did not start");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_last) else $error("expansion index overran");
    a_last_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> 32'(r_last) < Depth) else $error("schedule exceeds store");
`endif

endmodule

/* rtl/rrac_round_stage.sv */
// One pipelined cipher round, encrypt or decrypt: substitution/shift, column mix, key add.
`timescale 1ns / 1ps
module rrac_round_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_valid,
    input  logic                       i_dec,
    input  logic                       i_active,
    input  rrac_pkg::t_block           i_state,
    input  logic [127:0]               i_key,
    output logic                       o_valid,
    output logic                       o_dec,
    output rrac_pkg::t_block           o_state
);
    import rrac_pkg::*;

    t_block r_state;
    logic   r_valid;
    logic   r_dec;
    t_block n_state;

    // encrypt: sb/sr, mix, add key; decrypt: add key, inverse mix, inverse sr/sb
    always_comb begin
        if (!i_active) begin
            n_state = i_state;
        end else if (i_dec) begin
            n_state = dec_sr_sb(mix_cols(i_state ^ i_key, 1'b1));
        end else begin
            n_state = mix_cols(enc_sr_sb(i_state), 1'b0) ^ i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
            r_dec   <= i_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_state = r_state;

endmodule

/* rtl/reduced_round_aes_cipher.sv */
// Top level: config registers, key store, round pipeline and output handshake.
//
// Usage: write the key parts, key_size and round_count through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle. A write to
// a key part, key_size or round_count marks the round keys stale; the next
// transaction triggers a key expansion of 4*(Nr+1) words (44, 52 or 60), one
// word per cycle; o_ready stays low from the first waiting i_valid until the
// expansion is done. Blocks enter on i_valid/o_ready and results leave on
// o_valid/i_ready. The datapath is a pipeline of one initial key stage,
// MAX_ROUNDS round stages and one output key stage, each stage one register;
// a round past the active count passes the state through. One transaction
// enters per cycle while the keys are expanded and nothing stalls. Round
// keys sit in a register file filled by the expansion; every round stage
// reads two fixed round keys, one per direction, so no shared memory port
// is needed. When the receiver stalls the whole pipeline holds; nothing is
// lost or repeated. Synchronous active-low reset clears the valid bits, the
// expanded flag and the registers to their reset values (round_count 10).
`timescale 1ns / 1ps
module reduced_round_aes_cipher #(
    parameter int unsigned MAX_ROUNDS = rrac_pkg::MaxRoundsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrac_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [rrac_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [63:0]                   i_block_high,
    input  logic [63:0]                   i_block_low,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [63:0]                   o_result_high,
    output logic [63:0]                   o_result_low
);
    import rrac_pkg::*;

    localparam int unsigned Depth = 4 * (MAX_ROUNDS + 1);
    localparam int unsigned AW = $clog2(Depth);
    localparam int unsigned NS = MAX_ROUNDS + 1;

    logic [63:0] r_key [4];
    logic [1:0]  r_ksize;
    logic [3:0]  r_rounds;
    logic        r_expanded;
    logic [3:0]  r_nr_act;
    logic        r_kick;
    logic        r_load;

    logic          ke_busy;
    logic          ke_we;
    logic [AW-1:0] ke_waddr;
    logic [31:0]   ke_wdata;
    logic [3:0]    ke_nr;

    // per-round key registers, loaded while the expansion writes each word
    logic [31:0] r_rk [Depth];

    logic   s_valid [NS];
    logic   s_dec   [NS];
    t_block s_state [NS];
    logic   adv;
    logic   in_fire;
    logic [3:0] eff_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_ksize    <= 2'd0;
            r_rounds   <= 4'd10;
            r_expanded <= 1'b0;
            r_kick     <= 1'b0;
            r_load     <= 1'b0;
            r_nr_act   <= 4'd0;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY0:   r_key[0] <= i_cfg_data;
                    CFG_KEY1:   r_key[1] <= i_cfg_data;
                    CFG_KEY2:   r_key[2] <= i_cfg_data;
                    CFG_KEY3:   r_key[3] <= i_cfg_data;
                    CFG_KSIZE:  r_ksize  <= i_cfg_data[1:0];
                    CFG_ROUNDS: r_rounds <= i_cfg_data[3:0];
                    default: ;
                endcase
                if (32'(i_cfg_idx) <= 32'(CFG_ROUNDS)) r_expanded <= 1'b0;
            end else if (!r_expanded && !r_load && i_valid) begin
                r_kick <= 1'b1;
                r_load <= 1'b1;
            end else if (r_load && !r_kick && !ke_busy) begin
                r_load     <= 1'b0;
                r_expanded <= 1'b1;
                r_nr_act   <= ke_nr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ke_we) r_rk[ke_waddr] <= ke_wdata;
    end

    rrac_key_expand #(.MAX_ROUNDS(MAX_ROUNDS)) u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_key_size (r_ksize),
        .o_busy     (ke_busy),
        .o_we       (ke_we),
        .o_waddr    (ke_waddr),
        .o_wdata    (ke_wdata),
        .o_nr       (ke_nr)
    );

    assign eff_rounds = (r_rounds > r_nr_act) ? r_nr_act : r_rounds;
    assign adv        = !o_valid || i_ready;
    assign o_ready    = r_expanded && adv;
    assign in_fire    = i_valid && o_ready;

    // stage 0: initial key add for encryption; decrypt rounds run from the top
    logic   r_v0, r_d0;
    t_block r_s0;
    logic [3:0] r_eff;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= in_fire;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d0 <= i_req_type;
            r_s0 <= (i_req_type == REQ_DEC) ? {i_block_high, i_block_low}
                  : ({i_block_high, i_block_low} ^ {r_rk[0], r_rk[1], r_rk[2], r_rk[3]});
        end
        if (in_fire) r_eff <= eff_rounds;
    end

    assign s_valid[0] = r_v0;
    assign s_dec[0]   = r_d0;
    assign s_state[0] = r_s0;

    // stage k performs round k+1 for encryption; decryption uses the last
    // eff stages, stage MAX_ROUNDS-j applying key j for j up to eff
    genvar g;
    generate
        for (g = 0; g < MAX_ROUNDS; g++) begin : g_rnd
            logic         act;
            logic [3:0]   kidx;
            logic [127:0] key;
            always_comb begin
                if (s_dec[g]) begin
                    act  = (32'(g) + 32'(r_eff) >= MAX_ROUNDS);
                    kidx = 4'(MAX_ROUNDS - g);
                end else begin
                    act  = (32'(g) < 32'(r_eff));
                    kidx = 4'(g + 1);
                end
                key = {r_rk[AW'(4*kidx)], r_rk[AW'(4*kidx+1)],
                       r_rk[AW'(4*kidx+2)], r_rk[AW'(4*kidx+3)]};
            end
            rrac_round_stage u_rnd (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (adv),
                .i_valid  (s_valid[g]),
                .i_dec    (s_dec[g]),
                .i_active (act),
                .i_state  (s_state[g]),
                .i_key    (key),
                .o_valid  (s_valid[g+1]),
                .o_dec    (s_dec[g+1]),
                .o_state  (s_state[g+1])
            );
        end
    endgenerate

    // output stage: final key add for decryption
    logic   r_ov;
    t_block r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= s_valid[MAX_ROUNDS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= s_dec[MAX_ROUNDS]
                   ? (s_state[MAX_ROUNDS] ^ {r_rk[0], r_rk[1], r_rk[2], r_rk[3]})
                   : s_state[MAX_ROUNDS];
        end
    end

    assign o_valid       = r_ov;
    assign o_result_high = r_out[127:64];
    assign o_result_low  = r_out[63:0];

`ifndef SYNTHESIS
    a_no_accept_unexpanded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> r_expanded) else $error("accepted before key expansion");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_out))) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ke_busy |-> !o_ready) else $error("accept during expansion");
    a_nr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expanded |-> 32'(r_nr_act) <= MAX_ROUNDS) else $error("round bound");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for the reduced-round cipher: predicts every block result and checks it.
`timescale 1ns / 1ps
module tb_top;
    import rrac_pkg::*;

    localparam int unsigned LATENCY = MaxRoundsDefault + 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0] KSIZE_256 = 2'd2;
    localparam logic [1:0] KSIZE_ODD = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_NONE = 3'd6;

    typedef struct packed {
        logic        req;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_req_type = 1'b0;
    logic [63:0] i_block_high = '0;
    logic [63:0] i_block_low = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    reduced_round_aes_cipher DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_request pending_reqs[$];
    t_block expected_blocks[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit quiet = 1'b0;

    logic [7:0] fwd_sbox [256];
    logic [7:0] rev_sbox [256];
    logic [63:0] key_reg [4];
    logic [1:0] ksize_reg = KSIZE_128;
    logic [3:0] rounds_reg = 4'd10;
    logic [31:0] sched [60];
    int unsigned sched_rounds;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int s);
        return (x << s) | (x >> (8 - s));
    endfunction

    function automatic void build_sboxes();
        logic [7:0] inv, x;
        for (int v = 0; v < 256; v++) begin
            x = v[7:0];
            inv = 8'h01;
            for (int e = 0; e < 254; e++) inv = gf_mul(inv, x);
            fwd_sbox[v] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
        end
        for (int v = 0; v < 256; v++) rev_sbox[fwd_sbox[v]] = v[7:0];
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int unsigned nk;
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        case (ksize_reg)
            KSIZE_128: begin nk = 4; sched_rounds = 10; end
            KSIZE_192: begin nk = 6; sched_rounds = 12; end
            default: begin nk = 8; sched_rounds = 14; end
        endcase
        for (int i = 0; i < 4 * (sched_rounds + 1); i++) begin
            if (i < nk) begin
                sched[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
            end else begin
                t = sched[i - 1];
                if (i % nk == 0) begin
                    t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gf_mul(rc, 8'h02);
                end else if (nk == 8 && i % 8 == 4) begin
                    t = sub_w(t);
                end
                sched[i] = sched[i - nk] ^ t;
            end
        end
    endfunction

    function automatic t_block cipher_block(input logic dec, input t_block blk);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        int unsigned nr, rk;
        nr = (rounds_reg > sched_rounds) ? sched_rounds : rounds_reg;
        for (int n = 0; n < 16; n++) st[n] = blk[127 - 8 * n -: 8];
        for (int step = 0; step <= nr; step++) begin
            rk = dec ? nr - step : step;
            if (!dec && step > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4 * c + r] = fwd_sbox[st[4 * ((c + r) % 4) + r]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        st[4 * c + r] = gf_mul(8'h02, tmp[4 * c + r])
                            ^ gf_mul(8'h03, tmp[4 * c + (r + 1) % 4])
                            ^ tmp[4 * c + (r + 2) % 4] ^ tmp[4 * c + (r + 3) % 4];
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4 * c + r] ^= sched[4 * rk + c][31 - 8 * r -: 8];
            if (dec && step < nr) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4 * c + r] = gf_mul(8'h0e, st[4 * c + r])
                            ^ gf_mul(8'h0b, st[4 * c + (r + 1) % 4])
                            ^ gf_mul(8'h0d, st[4 * c + (r + 2) % 4])
                            ^ gf_mul(8'h09, st[4 * c + (r + 3) % 4]);
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        st[4 * c + r] = rev_sbox[tmp[4 * ((c + 4 - r) % 4) + r]];
            end
        end
        for (int n = 0; n < 16; n++) blk[127 - 8 * n -: 8] = st[n];
        return blk;
    endfunction

    // Driver: present queued transactions, with random bursts of idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_blocks.push_back(cipher_block(i_req_type, {i_block_high, i_block_low}));
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(0, 12);
                        i_valid <= 1'b0;
                    end else begin
                        i_valid <= 1'b1;
                        i_req_type <= pending_reqs[0].req;
                        i_block_high <= pending_reqs[0].hi;
                        i_block_low <= pending_reqs[0].lo;
                        void'(pending_reqs.pop_front());
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction and drive i_ready with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_blocks.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h %h", o_result_high, o_result_low);
                end else begin
                    if ({o_result_high, o_result_low} !== expected_blocks[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %h %h, got %h %h",
                                     expected_blocks[0][127:64], expected_blocks[0][63:0],
                                     o_result_high, o_result_low);
                    end
                    void'(expected_blocks.pop_front());
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_blocks.size() != 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KEY0: key_reg[0] = data;
            CFG_KEY1: key_reg[1] = data;
            CFG_KEY2: key_reg[2] = data;
            CFG_KEY3: key_reg[3] = data;
            CFG_KSIZE: ksize_reg = data[1:0];
            CFG_ROUNDS: rounds_reg = data[3:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_req(input logic req, input logic [63:0] hi, input logic [63:0] lo);
        t_request t;
        t.req = req;
        t.hi = hi;
        t.lo = lo;
        pending_reqs.push_back(t);
    endtask

    task automatic configure(input logic [1:0] ks, input logic [3:0] nr, input int key_kind);
        logic [63:0] k;
        for (int i = 0; i < 4; i++) begin
            k = (key_kind == 0) ? 64'h0 : (key_kind == 1) ? '1 : rand64();
            write_reg(CfgIdxW'(32'(CFG_KEY0) + i), k);
        end
        write_reg(CFG_KSIZE, {62'h0, ks});
        write_reg(CFG_ROUNDS, {60'h0, nr});
        write_reg(CFG_NONE, rand64());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        expand_schedule();
    endtask

    initial begin
        logic [1:0] ks_list [12];
        logic [3:0] nr_list [12];
        logic [63:0] hi, lo;
        ks_list = '{KSIZE_128, KSIZE_128, KSIZE_192, KSIZE_192, KSIZE_256, KSIZE_ODD,
                    KSIZE_256, KSIZE_128, KSIZE_192, KSIZE_256, KSIZE_128, KSIZE_256};
        nr_list = '{4'd10, 4'd0, 4'd12, 4'd15, 4'd14, 4'd14,
                    4'd1, 4'd15, 4'd5, 4'd0, 4'd7, 4'd14};
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        build_sboxes();
        expand_schedule();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req(REQ_ENC, 64'h0, 64'h0);
        queue_req(REQ_DEC, 64'h0, 64'h0);
        queue_req(REQ_ENC, '1, '1);
        queue_req(REQ_DEC, '1, '1);
        queue_req(REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_req(REQ_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        queue_req(REQ_ENC, 64'h8000000000000000, 64'h0000000000000001);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            configure(ks_list[ph], nr_list[ph], ph % 3);
            if (ph == 11) quiet = 1'b1;
            for (int n = 0; n < 92; n++) begin
                hi = rand64();
                lo = rand64();
                if ($urandom_range(0, 15) == 0) begin
                    hi = $urandom_range(0, 1) ? '1 : '0;
                    lo = $urandom_range(0, 1) ? '1 : '0;
                end
                queue_req(1'($urandom_range(0, 1)), hi, lo);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/rrac_pkg.sv
rtl/rrac_key_expand.sv
rtl/rrac_round_stage.sv
rtl/reduced_round_aes_cipher.sv
tb/tb_top.sv
